FILE: rtl/hsfr_pkg.sv
// Shared types and constants of the scaled HMM forward recursion block.
package hsfr_pkg;

   // Width of the states_in_use register and of the input value field.
   localparam int CSR_W     = 5;
   localparam int VALUE_W   = 16;
   localparam int ROW_LIMIT = 16;

   // Iteration counts of the log and divide units.
   localparam int SQ_STEPS  = 16;
   localparam int DIV_STEPS = 17;

   // ln(2) as an unsigned 0.32 fraction, and rounding constants.
   localparam logic [31:0] LN2_Q32    = 32'd2977044472;
   localparam logic [53:0] LN_ROUND   = 54'h0_0000_8000_0000;
   localparam int          RAW_ROUND  = 8192;
   localparam logic [16:0] PROB_ONE   = 17'd32768;
   localparam logic [4:0]  MSB_POS    = 5'd31;

   // Result kinds.
   localparam logic KIND_ALPHA  = 1'b0;
   localparam logic KIND_LOGLIK = 1'b1;

   // Operation codes of an input item.
   typedef enum logic [1:0] {
      FUNC_INIT   = 2'd0,
      FUNC_TRANS  = 2'd1,
      FUNC_LIK    = 2'd2,
      FUNC_FINISH = 2'd3
   } hsfr_func_type;

   // Input item.
   typedef struct packed {
      hsfr_func_type func;
      logic [3:0]    row;
      logic [3:0]    col;
      logic [15:0]   value;
   } hsfr_req_type;

   // Result item.
   typedef struct packed {
      logic               kind;
      logic [15:0]        prob;
      logic [3:0]         state_index;
      logic [15:0]        time_index;
      logic [31:0]        scale;
      logic signed [31:0] loglik;
      logic               zero_scale;
      logic               last;
   } hsfr_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;
      logic sum_issue;
      logic raw_lo;
      logic raw_hi;
      logic raw_wr;
      logic log_zero;
      logic log_start;
      logic log_norm;
      logic sq_mul;
      logic sq_adj;
      logic ln_mul;
      logic ln_add;
      logic raw_rd;
      logic div_start;
      logic div_step;
      logic emit_alpha;
      logic emit_finish;
   } hsfr_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      hsfr_func_type func;
      logic          row_ok;
      logic          first;
      logic          last_row;
      logic          scale_zero;
      logic          m_norm;
      logic          pipe_busy;
      logic          div_skip;
      logic          out_free;
   } hsfr_status_type;

endpackage

FILE: rtl/hmm_scaled_forward_recursion.sv
// Top level of the scaled HMM forward recursion block.
//
// Load items (func 0 and 1) fill the initial-probability vector and the
// transition matrix; likelihood items (func 2) arrive one per state for each
// time step; a finish item (func 3) returns the log-likelihood and restarts.
// Input and result channels use valid/stall; a transfer happens when valid is
// high and stall low. csr_wr_en writes the state count N.
// A likelihood item on the first step forms its raw alpha from the initial
// vector; later ones first run the one-product-a-cycle multiply-accumulate
// over the transition column. The item that completes a step also runs the
// log unit (start, normalising shifts, repeated squaring, then the multiply
// by ln 2 and the add) and the divider for each state (skipped when the
// quotient saturates or the scale is zero), before each of the N results
// goes out.
// Reset clears the scale, the log-likelihood and the step count and sets N to
// 16; the tables hold nothing until loaded. While the receiver stalls, the
// result register holds its transfer and the block waits to load the next one.
module hmm_scaled_forward_recursion #(
   parameter int MAX_STATES = 16,
   parameter int PROB_BITS  = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  hsfr_pkg::hsfr_req_type     req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output hsfr_pkg::hsfr_rsp_type     rsp_data,
   input  logic                       csr_wr_en,
   input  logic [hsfr_pkg::CSR_W-1:0] csr_wr_data
);
   import hsfr_pkg::*;

   localparam int DEPTH = (MAX_STATES < ROW_LIMIT) ? MAX_STATES : ROW_LIMIT;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int PW    = (PROB_BITS < VALUE_W) ? PROB_BITS : VALUE_W;

   hsfr_cmd_type    cmd;
   hsfr_status_type status;
   logic [IDX_W-1:0] idx;
   logic [IDX_W-1:0] last_idx;

   // Sequencer.
   hsfr_ctrl #(.IDX_W(IDX_W)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .last_idx  (last_idx),
      .cmd       (cmd),
      .idx       (idx)
   );

   // Arithmetic and storage.
   hsfr_dp #(.DEPTH(DEPTH), .IDX_W(IDX_W), .PW(PW)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .idx         (idx),
      .status      (status),
      .last_idx    (last_idx)
   );

   // A load item frees the input in the following cycle.
   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall &&
       (req_data.func == FUNC_INIT || req_data.func == FUNC_TRANS)) |=> !req_stall)
      else $error("load item held the input channel");

   // A normalised alpha never exceeds one.
   a_prob_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.prob <= 16'h8000))
      else $error("alpha above one");

   // A zero scale yields zero alphas.
   a_zero_scale: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_scale) |-> (rsp_data.prob == '0))
      else $error("non-zero alpha on zero scale");

   // A log-likelihood result is always the last and carries no alpha.
   a_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_LOGLIK) |->
         (rsp_data.last && rsp_data.prob == '0))
      else $error("malformed log-likelihood result");

endmodule

FILE: rtl/hsfr_ctrl.sv
// Controller state machine that sequences the forward recursion datapath.
module hsfr_ctrl #(
   parameter int IDX_W = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  hsfr_pkg::hsfr_status_type status,
   input  logic [IDX_W-1:0]          last_idx,
   output hsfr_pkg::hsfr_cmd_type    cmd,
   output logic [IDX_W-1:0]          idx
);
   import hsfr_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_FIN, S_SUM, S_DRAIN, S_RAW_LO, S_RAW_HI, S_RAW_WR, S_LOG,
      S_NORM, S_SQ_MUL, S_SQ_ADJ, S_LN_MUL, S_LN_ADD, S_RD, S_DIV_INIT,
      S_DIV, S_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [4:0]       cnt_ff, cnt_in;

   // Items are taken only while nothing is in progress.
   assign req_stall = (state_ff != S_IDLE);
   assign idx       = idx_ff;

   // Next state and commands.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               case (status.func)
                  FUNC_FINISH: state_in = S_FIN;
                  FUNC_LIK: begin
                     if (status.row_ok) begin
                        idx_in   = '0;
                        state_in = status.first ? S_RAW_LO : S_SUM;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_FIN: begin
            if (status.out_free) begin
               cmd.emit_finish = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_SUM: begin
            cmd.sum_issue = 1'b1;
            if (idx_ff == last_idx) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            if (!status.pipe_busy) state_in = S_RAW_LO;
         end
         S_RAW_LO: begin
            cmd.raw_lo = 1'b1;
            state_in   = status.first ? S_RAW_WR : S_RAW_HI;
         end
         S_RAW_HI: begin
            cmd.raw_hi = 1'b1;
            state_in   = S_RAW_WR;
         end
         S_RAW_WR: begin
            cmd.raw_wr = 1'b1;
            state_in   = status.last_row ? S_LOG : S_IDLE;
         end
         S_LOG: begin
            if (status.scale_zero) begin
               cmd.log_zero = 1'b1;
               idx_in       = '0;
               state_in     = S_RD;
            end else begin
               cmd.log_start = 1'b1;
               state_in      = S_NORM;
            end
         end
         S_NORM: begin
            if (status.m_norm) begin
               cnt_in   = '0;
               state_in = S_SQ_MUL;
            end else begin
               cmd.log_norm = 1'b1;
            end
         end
         S_SQ_MUL: begin
            cmd.sq_mul = 1'b1;
            state_in   = S_SQ_ADJ;
         end
         S_SQ_ADJ: begin
            cmd.sq_adj = 1'b1;
            if (cnt_ff == 5'(SQ_STEPS - 1)) begin
               state_in = S_LN_MUL;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_SQ_MUL;
            end
         end
         S_LN_MUL: begin
            cmd.ln_mul = 1'b1;
            state_in   = S_LN_ADD;
         end
         S_LN_ADD: begin
            cmd.ln_add = 1'b1;
            idx_in     = '0;
            state_in   = S_RD;
         end
         S_RD: begin
            cmd.raw_rd = 1'b1;
            state_in   = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.div_start = 1'b1;
            cnt_in        = '0;
            state_in      = status.div_skip ? S_EMIT : S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == 5'(DIV_STEPS - 1)) begin
               state_in = S_EMIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit_alpha = 1'b1;
               if (idx_ff == last_idx) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and loop counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

FILE: rtl/hsfr_dp.sv
// Datapath: probability tables, multiply-accumulate, log unit, divider, result register.
module hsfr_dp #(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4,
   parameter int PW    = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  hsfr_pkg::hsfr_req_type       req_data,
   input  logic                         csr_wr_en,
   input  logic [hsfr_pkg::CSR_W-1:0]   csr_wr_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output hsfr_pkg::hsfr_rsp_type       rsp_data,
   input  hsfr_pkg::hsfr_cmd_type       cmd,
   input  logic [IDX_W-1:0]             idx,
   output hsfr_pkg::hsfr_status_type    status,
   output logic [IDX_W-1:0]             last_idx
);
   import hsfr_pkg::*;

   localparam int PROD_W = 2 * PW;
   localparam int SUM_W  = PROD_W + IDX_W;
   localparam int HI_W   = SUM_W - 16;
   localparam int ACC_W  = SUM_W + PW + 1;

   // Stores.
   logic [PW-1:0] init_mem  [DEPTH];
   logic [PW-1:0] trans_mem [DEPTH*DEPTH];
   logic [PW-1:0] prev_mem  [DEPTH];
   logic [31:0]   raw_mem   [DEPTH];

   logic [CSR_W-1:0]   states_ff;
   logic [4:0]         n_last;
   logic [3:0]         row_ff;
   logic [PW-1:0]      lik_ff;
   logic [PW-1:0]      init_rd_ff, pa_rd_ff, tr_rd_ff;
   logic               rd_v_ff, prod_v_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [ACC_W-1:0]   t_ff;
   logic [PROD_W-1:0]  first_prod;
   logic [15+PW:0]     lo_prod;
   logic [HI_W+PW-1:0] hi_prod;
   logic [63:0]        t_wide, t_shift;
   logic [31:0]        raw_val;
   logic [32:0]        scale_sum;
   logic [31:0]        scale_ff;
   logic signed [31:0] loglik_ff;
   logic               first_ff;
   logic [15:0]        step_ff;
   logic [31:0]        m_ff;
   logic [4:0]         p_ff;
   logic [15:0]        frac_ff;
   logic [63:0]        sq_ff;
   logic [32:0]        sq_top;
   logic [20:0]        mag;
   logic [52:0]        ln_mul_w;
   logic [53:0]        ln_prod_ff;
   logic signed [33:0] ll_delta, ll_sum;
   logic signed [31:0] ll_sat;
   logic [31:0]        raw_rd_ff;
   logic [47:0]        dividend;
   logic [31:0]        rem_ff;
   logic [16:0]        dlo_ff;
   logic [16:0]        q_ff;
   logic               sat_ff;
   logic [32:0]        trial;
   logic               trial_ge;
   logic [16:0]        p_val;
   logic               scale_zero;
   logic               rsp_valid_ff;
   hsfr_rsp_type       rsp_ff;
   logic               out_free;
   logic               step_last;

   // Configuration register and the clamped state count.
   always_ff @(posedge clock) begin
      if (reset) begin
         states_ff <= CSR_W'(16);
      end else if (csr_wr_en) begin
         states_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (states_ff == '0) begin
         n_last = '0;
      end else if (states_ff > 5'(DEPTH)) begin
         n_last = 5'(DEPTH - 1);
      end else begin
         n_last = states_ff - 1'b1;
      end
   end

   assign last_idx  = n_last[IDX_W-1:0];
   assign step_last = (idx == last_idx);

   // Item registers, latched on each transfer.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         row_ff <= req_data.row;
         lik_ff <= req_data.value[PW-1:0];
      end
   end

   // Initial probabilities: load writes, read at the item's row on transfer.
   always_ff @(posedge clock) begin
      if (cmd.take && req_data.func == FUNC_INIT && {1'b0, req_data.row} < 5'(DEPTH)) begin
         init_mem[req_data.row[IDX_W-1:0]] <= req_data.value[PW-1:0];
      end
      if (cmd.take) begin
         init_rd_ff <= init_mem[req_data.row[IDX_W-1:0]];
      end
   end

   // Transition matrix: one read per cycle during the sum.
   always_ff @(posedge clock) begin
      if (cmd.take && req_data.func == FUNC_TRANS && {1'b0, req_data.row} < 5'(DEPTH)
          && {1'b0, req_data.col} < 5'(DEPTH)) begin
         trans_mem[{req_data.row[IDX_W-1:0], req_data.col[IDX_W-1:0]}] <=
            req_data.value[PW-1:0];
      end
      if (cmd.sum_issue) begin
         tr_rd_ff <= trans_mem[{idx, row_ff[IDX_W-1:0]}];
      end
   end

   // Previous normalised alphas: written as each result leaves, read in the sum.
   always_ff @(posedge clock) begin
      if (cmd.emit_alpha) begin
         prev_mem[idx] <= p_val[PW-1:0];
      end
      if (cmd.sum_issue) begin
         pa_rd_ff <= prev_mem[idx];
      end
   end

   // Multiply-accumulate pipeline: read, multiply, accumulate.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff   <= 1'b0;
         prod_v_ff <= 1'b0;
      end else begin
         rd_v_ff   <= cmd.sum_issue;
         prod_v_ff <= rd_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= pa_rd_ff * tr_rd_ff;
      if (cmd.take) begin
         sum_ff <= '0;
      end else if (prod_v_ff) begin
         sum_ff <= sum_ff + SUM_W'(prod_ff);
      end
   end

   // Raw alpha: the likelihood times the sum in two parts, or times init on the first step.
   assign first_prod = init_rd_ff * lik_ff;
   assign lo_prod    = sum_ff[15:0] * lik_ff;
   assign hi_prod    = sum_ff[SUM_W-1:16] * lik_ff;

   always_ff @(posedge clock) begin
      if (cmd.raw_lo) begin
         if (first_ff) begin
            t_ff <= ACC_W'({first_prod, 1'b0});
         end else begin
            t_ff <= ACC_W'(lo_prod) + ACC_W'(RAW_ROUND);
         end
      end else if (cmd.raw_hi) begin
         t_ff <= t_ff + (ACC_W'(hi_prod) << 16);
      end
   end

   assign t_wide    = 64'(t_ff);
   assign t_shift   = first_ff ? t_wide : (t_wide >> 14);
   assign raw_val   = (|t_shift[63:32]) ? '1 : t_shift[31:0];
   assign scale_sum = {1'b0, scale_ff} + {1'b0, raw_val};

   // Raw alpha store.
   always_ff @(posedge clock) begin
      if (cmd.raw_wr) begin
         raw_mem[row_ff[IDX_W-1:0]] <= raw_val;
      end
      if (cmd.raw_rd) begin
         raw_rd_ff <= raw_mem[idx];
      end
   end

   assign scale_zero = (scale_ff == '0);

   // Log unit: normalise, square sixteen times, multiply by ln 2.
   assign sq_top = sq_ff[63:31];
   assign mag    = (p_ff == MSB_POS) ? 21'(frac_ff)
                                     : {(MSB_POS - p_ff), 16'd0} - 21'(frac_ff);
   assign ln_mul_w = mag * LN2_Q32;

   always_ff @(posedge clock) begin
      if (cmd.log_start) begin
         m_ff    <= scale_ff;
         p_ff    <= MSB_POS;
         frac_ff <= '0;
      end else if (cmd.log_norm) begin
         m_ff <= m_ff << 1;
         p_ff <= p_ff - 1'b1;
      end else if (cmd.sq_adj) begin
         if (sq_top[32]) begin
            m_ff    <= sq_top[32:1];
            frac_ff <= {frac_ff[14:0], 1'b1};
         end else begin
            m_ff    <= sq_top[31:0];
            frac_ff <= {frac_ff[14:0], 1'b0};
         end
      end
      if (cmd.sq_mul) begin
         sq_ff <= m_ff * m_ff;
      end
      if (cmd.ln_mul) begin
         ln_prod_ff <= {1'b0, ln_mul_w} + LN_ROUND;
      end
   end

   // Saturating update of the log-likelihood.
   always_comb begin
      if (cmd.log_zero) begin
         ll_delta = -34'sd2147483648;
      end else if (p_ff != MSB_POS) begin
         ll_delta = -$signed({12'd0, ln_prod_ff[53:32]});
      end else begin
         ll_delta = $signed({12'd0, ln_prod_ff[53:32]});
      end
      ll_sum = 34'(loglik_ff) + ll_delta;
      if (ll_sum > 34'sd2147483647) begin
         ll_sat = 32'sh7FFF_FFFF;
      end else if (ll_sum < -34'sd2147483648) begin
         ll_sat = 32'sh8000_0000;
      end else begin
         ll_sat = ll_sum[31:0];
      end
   end

   // Restoring divider: one quotient bit a cycle, overflow found up front.
   assign dividend = {1'b0, raw_rd_ff, 15'd0} + 48'(scale_ff >> 1);
   assign trial    = {rem_ff, dlo_ff[16]};
   assign trial_ge = (trial >= {1'b0, scale_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff <= {1'b0, dividend[47:17]};
         dlo_ff <= dividend[16:0];
         q_ff   <= '0;
         sat_ff <= ({1'b0, dividend[47:17]} >= scale_ff);
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? 32'(trial - {1'b0, scale_ff}) : trial[31:0];
         dlo_ff <= dlo_ff << 1;
         q_ff   <= {q_ff[15:0], trial_ge};
      end
   end

   always_comb begin
      if (scale_zero) begin
         p_val = '0;
      end else if (sat_ff || q_ff > PROB_ONE) begin
         p_val = PROB_ONE;
      end else begin
         p_val = q_ff;
      end
   end

   // Sequence state: scale, log-likelihood, first-step flag and step count.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= '0;
         loglik_ff <= '0;
         first_ff  <= 1'b1;
         step_ff   <= '0;
      end else if (cmd.emit_finish) begin
         scale_ff  <= '0;
         loglik_ff <= '0;
         first_ff  <= 1'b1;
         step_ff   <= '0;
      end else if (cmd.emit_alpha && step_last) begin
         scale_ff <= '0;
         first_ff <= 1'b0;
         step_ff  <= step_ff + 1'b1;
      end else begin
         if (cmd.raw_wr) begin
            scale_ff <= scale_sum[32] ? '1 : scale_sum[31:0];
         end
         if (cmd.log_zero || cmd.ln_add) begin
            loglik_ff <= ll_sat;
         end
      end
   end

   // Result register; a new result loads when it is empty or the old one transfers.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_alpha || cmd.emit_finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_alpha) begin
         rsp_ff.kind        <= KIND_ALPHA;
         rsp_ff.prob        <= p_val[15:0];
         rsp_ff.state_index <= 4'(idx);
         rsp_ff.time_index  <= step_ff;
         rsp_ff.scale       <= scale_ff;
         rsp_ff.loglik      <= loglik_ff;
         rsp_ff.zero_scale  <= scale_zero;
         rsp_ff.last        <= step_last;
      end else if (cmd.emit_finish) begin
         rsp_ff.kind        <= KIND_LOGLIK;
         rsp_ff.prob        <= '0;
         rsp_ff.state_index <= '0;
         rsp_ff.time_index  <= step_ff;
         rsp_ff.scale       <= '0;
         rsp_ff.loglik      <= loglik_ff;
         rsp_ff.zero_scale  <= 1'b0;
         rsp_ff.last        <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Status to the controller.
   assign status.func       = req_data.func;
   assign status.row_ok     = ({1'b0, req_data.row} <= n_last);
   assign status.first      = first_ff;
   assign status.last_row   = ({1'b0, row_ff} == n_last);
   assign status.scale_zero = scale_zero;
   assign status.m_norm     = m_ff[31];
   assign status.pipe_busy  = rd_v_ff || prod_v_ff;
   assign status.div_skip   = scale_zero || ({1'b0, dividend[47:17]} >= scale_ff);
   assign status.out_free   = out_free;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench of the scaled HMM forward recursion block.
`timescale 1ns / 100ps

module tb_top;
   import hsfr_pkg::*;

   localparam int SETTLE_CYCLES = 64;
   localparam int MAX_RANDOM_N  = 6;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   hsfr_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   hsfr_rsp_type rsp_data;
   logic         csr_wr_en = 1'b0;
   logic [CSR_W-1:0] csr_wr_data = '0;

   // Shadow copy of the recursion state.
   logic [15:0] fwd_init [16];
   logic [15:0] fwd_trans [16][16];
   logic [15:0] fwd_prev [16];
   logic [31:0] fwd_raw [16];
   logic [31:0] fwd_scale;
   int          fwd_loglik;
   bit          fwd_first;
   logic [15:0] fwd_step;
   logic [4:0]  fwd_nreg;

   hsfr_rsp_type rsp_expected [$];
   int error_count = 0;
   int rsp_seen = 0;
   int steps_sent = 0;
   int zero_steps = 0;
   int burst_left = 0;
   int stall_pct = 0;
   int stall_seg = 0;

   hmm_scaled_forward_recursion i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   // Effective state count after clamping the register.
   function automatic int eff_states();
      if (fwd_nreg < 5'd1) return 1;
      if (fwd_nreg > 5'd16) return 16;
      return int'(fwd_nreg);
   endfunction

   function automatic logic [31:0] sat_u32(logic [63:0] x);
      return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
   endfunction

   // Natural log of a Q1.31 scale, as Q16.16.
   function automatic longint ln_of_scale(logic [31:0] x);
      int          p;
      logic [63:0] m;
      logic [15:0] frac;
      longint      l2, mag, r;
      p = 31;
      frac = '0;
      while (p > 0 && x[p] == 1'b0) p--;
      m = 64'(x) << (31 - p);
      for (int k = 0; k < 16; k++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      l2 = longint'(p - 31) * 65536 + longint'(frac);
      mag = (l2 < 0) ? -l2 : l2;
      r = longint'((64'(mag) * 64'(LN2_Q32) + 64'h8000_0000) >> 32);
      return (l2 < 0) ? -r : r;
   endfunction

   // Works out the results that one accepted item causes.
   task automatic forward_predict(hsfr_req_type r);
      int           n;
      logic [63:0]  sum, p;
      logic [31:0]  sc;
      longint       ll;
      hsfr_rsp_type e;
      n = eff_states();
      case (r.func)
         FUNC_INIT: fwd_init[r.row] = r.value;
         FUNC_TRANS: fwd_trans[r.row][r.col] = r.value;
         FUNC_FINISH: begin
            e = '0;
            e.kind = KIND_LOGLIK;
            e.time_index = fwd_step;
            e.loglik = fwd_loglik;
            e.last = 1'b1;
            rsp_expected.push_back(e);
            fwd_first = 1'b1;
            fwd_step = '0;
            fwd_loglik = 0;
            fwd_scale = '0;
         end
         default: begin
            if (int'(r.row) < n) begin
               if (fwd_first) begin
                  fwd_raw[r.row] = sat_u32((64'(fwd_init[r.row]) * 64'(r.value)) << 1);
               end else begin
                  sum = '0;
                  for (int i = 0; i < n; i++)
                     sum += 64'(fwd_prev[i]) * 64'(fwd_trans[i][r.row]);
                  fwd_raw[r.row] = sat_u32((sum * 64'(r.value) + 64'(RAW_ROUND)) >> 14);
               end
               fwd_scale = sat_u32(64'(fwd_scale) + 64'(fwd_raw[r.row]));
               if (int'(r.row) == n - 1) begin
                  sc = fwd_scale;
                  if (sc == 0) zero_steps++;
                  ll = longint'(fwd_loglik) + ((sc == 0) ? -64'sd2147483648 : ln_of_scale(sc));
                  if (ll < -64'sd2147483648) ll = -64'sd2147483648;
                  if (ll > 64'sd2147483647) ll = 64'sd2147483647;
                  fwd_loglik = int'(ll);
                  for (int i = 0; i < n; i++) begin
                     p = '0;
                     if (sc != 0) begin
                        p = ((64'(fwd_raw[i]) << 15) + 64'(sc >> 1)) / 64'(sc);
                        if (p > 64'd32768) p = 64'd32768;
                     end
                     fwd_prev[i] = p[15:0];
                     e = '0;
                     e.kind = KIND_ALPHA;
                     e.prob = p[15:0];
                     e.state_index = 4'(i);
                     e.time_index = fwd_step;
                     e.scale = sc;
                     e.loglik = fwd_loglik;
                     e.zero_scale = (sc == 0);
                     e.last = (i == n - 1);
                     rsp_expected.push_back(e);
                  end
                  fwd_scale = '0;
                  fwd_first = 1'b0;
                  fwd_step = fwd_step + 16'd1;
                  steps_sent++;
               end
            end
         end
      endcase
   endtask

   // Sends one item in bursts with random gaps, and predicts it on transfer.
   task automatic send_item(hsfr_func_type f, int row, int col, int value);
      hsfr_req_type r;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      r.func = f;
      r.row = 4'(row);
      r.col = 4'(col);
      r.value = 16'(value);
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      forward_predict(r);
   endtask

   // Waits until every expected result has arrived and the block has settled.
   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_states(int v);
      wait_drained();
      csr_wr_data <= 5'(v);
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      fwd_nreg = 5'(v);
   endtask

   function automatic int rand_prob();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 32768;
         default: return $urandom_range(0, 32768);
      endcase
   endfunction

   // One complete step: every row below N written, row N-1 last.
   task automatic send_step(int n, bit all_zero);
      for (int r = 0; r < n; r++) begin
         if (r > 0 && $urandom_range(0, 7) == 0)
            send_item(FUNC_LIK, $urandom_range(0, r - 1), $urandom_range(0, 15),
                      all_zero ? 0 : rand_prob());
         send_item(FUNC_LIK, r, $urandom_range(0, 15), all_zero ? 0 : rand_prob());
      end
   endtask

   // Every entry that a later step can read is loaded before use; larger state
   // counts are only run for a first step, which reads the initial vector alone.
   task automatic test_table_load();
      for (int i = 0; i < 16; i++) send_item(FUNC_INIT, i, $urandom_range(0, 15), rand_prob());
      for (int i = 0; i < MAX_RANDOM_N; i++)
         for (int j = 0; j < MAX_RANDOM_N; j++) send_item(FUNC_TRANS, i, j, rand_prob());
   endtask

   // Extremes, out-of-order rows, zero scale, ignored rows and early finish.
   task automatic test_directed();
      write_states(2);
      send_item(FUNC_INIT, 0, 0, 32768);
      send_item(FUNC_INIT, 1, 0, 0);
      send_item(FUNC_TRANS, 0, 1, 32768);
      send_item(FUNC_TRANS, 1, 0, 0);
      send_item(FUNC_LIK, 0, 0, 32768);
      send_item(FUNC_LIK, 1, 15, 32768);
      send_item(FUNC_LIK, 1, 0, 0);
      send_item(FUNC_LIK, 0, 0, 32768);
      send_item(FUNC_LIK, 1, 0, 32768);
      send_item(FUNC_LIK, 0, 0, 0);
      send_item(FUNC_LIK, 1, 0, 0);
      send_item(FUNC_LIK, 9, 0, 32768);
      send_item(FUNC_LIK, 15, 0, 32768);
      send_item(FUNC_LIK, 0, 0, 12345);
      send_item(FUNC_FINISH, 0, 0, 0);
      send_item(FUNC_FINISH, 15, 15, 65535);
   endtask

   // Clamped register extremes with full-size steps.
   task automatic test_state_count_extremes();
      write_states(0);
      send_step(1, 1'b0);
      send_item(FUNC_FINISH, 0, 0, 0);
      write_states(31);
      send_step(16, 1'b0);
      send_item(FUNC_FINISH, 0, 0, 0);
   endtask

   // Random sequences, mostly well formed, with noise and broken steps.
   task automatic test_random_sequences();
      int items, n, v;
      items = 0;
      while (items < 16) begin
         case ($urandom_range(0, 3))
            0: v = 0;
            1: v = MAX_RANDOM_N;
            default: v = $urandom_range(1, MAX_RANDOM_N);
         endcase
         write_states(v);
         n = eff_states();
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 3) == 0) begin
               send_item(hsfr_func_type'($urandom_range(0, 1)), $urandom_range(0, 15),
                         $urandom_range(0, 15), rand_prob());
               if (n < 16) send_item(FUNC_LIK, $urandom_range(n, 15), 0, rand_prob());
            end
            send_step(n, $urandom_range(0, 6) == 0);
            items += n;
         end
         if (n > 1 && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, n - 1))
               send_item(FUNC_LIK, $urandom_range(0, n - 2), 0, rand_prob());
         end
         send_item(FUNC_FINISH, $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 65535));
         items++;
      end
   endtask

   // Receiver stall pattern: segments with their own stall rate.
   always @(posedge clock) begin
      if (stall_seg == 0) begin
         stall_seg <= $urandom_range(10, 200);
         case ($urandom_range(0, 3))
            0: stall_pct <= 0;
            1: stall_pct <= 25;
            2: stall_pct <= 75;
            default: stall_pct <= 95;
         endcase
      end else begin
         stall_seg <= stall_seg - 1;
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   function automatic void check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         error_count++;
      end
   endfunction

   // Compares every result transfer with the oldest expectation.
   always @(posedge clock) begin
      hsfr_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (rsp_expected.size() == 0) begin
            $error("unexpected result transfer: %h", rsp_data);
            error_count++;
         end else begin
            e = rsp_expected.pop_front();
            check_field("kind", e.kind, rsp_data.kind);
            check_field("prob", e.prob, rsp_data.prob);
            check_field("state_index", e.state_index, rsp_data.state_index);
            check_field("time_index", e.time_index, rsp_data.time_index);
            check_field("scale", e.scale, rsp_data.scale);
            check_field("loglik", e.loglik, rsp_data.loglik);
            check_field("zero_scale", e.zero_scale, rsp_data.zero_scale);
            check_field("last", e.last, rsp_data.last);
         end
      end
   end

   initial begin
      #4000000;
      $display("[hmm_scaled_forward_recursion] ERROR");
      $finish;
   end

   initial begin
      fwd_nreg = 5'd16;
      fwd_scale = '0;
      fwd_loglik = 0;
      fwd_first = 1'b1;
      fwd_step = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table_load();
      test_directed();
      test_state_count_extremes();
      test_random_sequences();
      wait_drained();
      if (rsp_expected.size() != 0) begin
         $error("%0d expected results never arrived", rsp_expected.size());
         error_count++;
      end
      $display("Covered %0d completed steps (%0d with zero scale) and %0d results,",
               steps_sent, zero_steps, rsp_seen);
      $display("across state counts from 1 to 16 with random sender gaps and stalls.");
      if (error_count == 0) begin
         $display("[hmm_scaled_forward_recursion] OK");
      end else begin
         $display("[hmm_scaled_forward_recursion] ERROR");
      end
      $finish;
   end

endmodule
